FILE: rtl/tfill_pkg.sv
// Package for the rectangle fill byte stream: constants, register indexes
// and the entry type passed from the front part to the back part.
// No dependencies.
`timescale 1ns / 1ps

package tfill_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [7:0] CMD_COL_SET   = 8'h2A;
    localparam logic [7:0] CMD_ROW_SET   = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;

    localparam logic [9:0] PANEL_WIDTH_RESET  = 10'd128;
    localparam logic [9:0] PANEL_HEIGHT_RESET = 10'd160;

    // Configuration register indexes
    localparam logic REG_PANEL_WIDTH  = 1'b0;
    localparam logic REG_PANEL_HEIGHT = 1'b1;

    // Input command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Classified item, ready for the back part to carry out
    typedef struct packed {
        logic        is_start;
        logic        skip;
        logic        empty_job;
        logic [15:0] start_col;
        logic [15:0] end_col;
        logic [15:0] start_row;
        logic [15:0] end_row;
        logic [15:0] colour;
        logic [15:0] pixels;
    } tfill_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } tfill_queue_status_t;

endpackage

FILE: rtl/tfill_if.sv
// Channel interfaces: request items, result items and the configuration
// write channel. Depends on nothing but the handshake convention.
`timescale 1ns / 1ps

interface tfill_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [7:0]  rect_width;
    logic [7:0]  rect_height;
    logic [15:0] fill_colour;

    modport source (output valid, command, origin_x, origin_y, rect_width, rect_height,
                    fill_colour, input ready);
    modport sink   (input valid, command, origin_x, origin_y, rect_width, rect_height,
                    fill_colour, output ready);
endinterface

interface tfill_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       is_data;
    logic       last;

    modport source (output valid, byte_out, is_data, last, input ready);
    modport sink   (input valid, byte_out, is_data, last, output ready);
endinterface

interface tfill_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [9:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/tfill_front.sv
// Front part: accepts request items, holds the panel size registers and
// turns each request item into a ready-made window entry. Uses tfill_pkg.
`timescale 1ns / 1ps

module tfill_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    tfill_req_if.sink                     req,
    tfill_cfg_if.sink                     cfg,
    input  tfill_pkg::tfill_queue_status_t q_status,
    output logic                          push,
    output tfill_pkg::tfill_entry_t       push_entry
);

    logic [9:0]  panel_width_reg;
    logic [9:0]  panel_height_reg;
    logic        on_panel;
    logic [15:0] pixels;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_width_reg  <= tfill_pkg::PANEL_WIDTH_RESET;
            panel_height_reg <= tfill_pkg::PANEL_HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                tfill_pkg::REG_PANEL_WIDTH:  panel_width_reg  <= cfg.data;
                tfill_pkg::REG_PANEL_HEIGHT: panel_height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign req.ready = !q_status.full;
    assign push      = req.valid && !q_status.full;

    assign on_panel = (req.origin_x < {6'd0, panel_width_reg})
                   && (req.origin_y < {6'd0, panel_height_reg});
    assign pixels = {8'd0, req.rect_width} * {8'd0, req.rect_height};

    always_comb
    begin
        push_entry.is_start  = (req.command == tfill_pkg::CMD_START);
        push_entry.skip      = !on_panel;
        push_entry.empty_job = !on_panel && (pixels == 16'd0);
        push_entry.start_col = req.origin_x;
        push_entry.start_row = req.origin_y;
        push_entry.end_col   = req.origin_x + {8'd0, req.rect_width} - 16'd1;
        push_entry.end_row   = req.origin_y + {8'd0, req.rect_height} - 16'd1;
        push_entry.colour    = req.fill_colour;
        push_entry.pixels    = pixels;
    end

endmodule

FILE: rtl/tfill_queue.sv
// Short first-in first-out queue of classified entries between the front
// and back parts. Uses tfill_pkg.
`timescale 1ns / 1ps

module tfill_queue
#(
    parameter int unsigned DEPTH = tfill_pkg::QUEUE_DEPTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  tfill_pkg::tfill_entry_t        push_entry,
    input  logic                           pop,
    output tfill_pkg::tfill_entry_t        pop_entry,
    output tfill_pkg::tfill_queue_status_t status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    tfill_pkg::tfill_entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_entry    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
    a_full_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
        status.full && !do_pop |=> status.full)
        else $error("full queue lost an entry without a pop");
    a_empty_stays: assert property (@(posedge clk) disable iff (!rst_n)
        status.empty && !push |=> status.empty)
        else $error("empty queue gained an entry without a push");

endmodule

FILE: rtl/tfill_back.sv
// Back part: carries out queued entries, walks the window header and the
// colour pixels, and holds the result in an output register. Uses tfill_pkg.
`timescale 1ns / 1ps

module tfill_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  tfill_pkg::tfill_entry_t        pop_entry,
    input  tfill_pkg::tfill_queue_status_t q_status,
    output logic                           pop,
    tfill_rsp_if.source                    rsp
);

    localparam logic [3:0] STEP_COL_CMD  = 4'd0;
    localparam logic [3:0] STEP_SC_HI    = 4'd1;
    localparam logic [3:0] STEP_SC_LO    = 4'd2;
    localparam logic [3:0] STEP_EC_HI    = 4'd3;
    localparam logic [3:0] STEP_EC_LO    = 4'd4;
    localparam logic [3:0] STEP_ROW_CMD  = 4'd5;
    localparam logic [3:0] STEP_SR_HI    = 4'd6;
    localparam logic [3:0] STEP_SR_LO    = 4'd7;
    localparam logic [3:0] STEP_ER_HI    = 4'd8;
    localparam logic [3:0] STEP_ER_LO    = 4'd9;
    localparam logic [3:0] STEP_MEM_CMD  = 4'd10;
    localparam logic [3:0] STEP_COLOUR   = 4'd11;

    logic        busy_reg, busy_next;
    logic [3:0]  step_reg, step_next;
    logic        low_half_reg, low_half_next;
    logic [15:0] pixels_reg, pixels_next;
    logic [15:0] start_col_reg, end_col_reg, start_row_reg, end_row_reg, colour_reg;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        is_data_reg, is_data_next;
    logic        last_reg, last_next;

    logic        load_ok;
    logic        has_result;
    logic        load_job;

    assign load_ok = !out_valid_reg || rsp.ready;
    assign pop     = load_ok && !q_status.empty;

    assign rsp.valid    = out_valid_reg;
    assign rsp.byte_out = byte_reg;
    assign rsp.is_data  = is_data_reg;
    assign rsp.last     = last_reg;

    always_comb
    begin
        busy_next     = busy_reg;
        step_next     = step_reg;
        low_half_next = low_half_reg;
        pixels_next   = pixels_reg;
        has_result    = 1'b0;
        load_job      = 1'b0;
        byte_next     = byte_reg;
        is_data_next  = 1'b1;
        last_next     = 1'b0;

        if (pop)
        begin
            if (pop_entry.is_start)
            begin
                if (!busy_reg)
                begin
                    load_job      = 1'b1;
                    pixels_next   = pop_entry.pixels;
                    low_half_next = 1'b0;
                    step_next     = pop_entry.skip ? STEP_COLOUR : STEP_COL_CMD;
                    busy_next     = !pop_entry.empty_job;
                end
            end
            else if (busy_reg)
            begin
                if (step_reg != STEP_COLOUR)
                begin
                    has_result = 1'b1;
                    case (step_reg)
                        STEP_COL_CMD: begin byte_next = tfill_pkg::CMD_COL_SET; is_data_next = 1'b0; end
                        STEP_SC_HI:   byte_next = start_col_reg[15:8];
                        STEP_SC_LO:   byte_next = start_col_reg[7:0];
                        STEP_EC_HI:   byte_next = end_col_reg[15:8];
                        STEP_EC_LO:   byte_next = end_col_reg[7:0];
                        STEP_ROW_CMD: begin byte_next = tfill_pkg::CMD_ROW_SET; is_data_next = 1'b0; end
                        STEP_SR_HI:   byte_next = start_row_reg[15:8];
                        STEP_SR_LO:   byte_next = start_row_reg[7:0];
                        STEP_ER_HI:   byte_next = end_row_reg[15:8];
                        STEP_ER_LO:   byte_next = end_row_reg[7:0];
                        default:      begin byte_next = tfill_pkg::CMD_MEM_WRITE; is_data_next = 1'b0; end
                    endcase
                    if (step_reg == STEP_MEM_CMD && pixels_reg == 16'd0)
                    begin
                        last_next = 1'b1;
                        busy_next = 1'b0;
                    end
                    step_next = step_reg + 4'd1;
                end
                else if (pixels_reg == 16'd0)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    has_result = 1'b1;
                    if (!low_half_reg)
                    begin
                        byte_next     = colour_reg[15:8];
                        low_half_next = 1'b1;
                    end
                    else
                    begin
                        byte_next     = colour_reg[7:0];
                        low_half_next = 1'b0;
                        pixels_next   = pixels_reg - 16'd1;
                        if (pixels_reg == 16'd1)
                        begin
                            last_next = 1'b1;
                            busy_next = 1'b0;
                        end
                    end
                end
            end
        end

        if (pop)
        begin
            out_valid_next = has_result;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= STEP_COL_CMD;
            low_half_reg  <= 1'b0;
            pixels_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            low_half_reg  <= low_half_next;
            pixels_reg    <= pixels_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_job)
        begin
            start_col_reg <= pop_entry.start_col;
            end_col_reg   <= pop_entry.end_col;
            start_row_reg <= pop_entry.start_row;
            end_row_reg   <= pop_entry.end_row;
            colour_reg    <= pop_entry.colour;
        end
        if (pop && has_result)
        begin
            byte_reg    <= byte_next;
            is_data_reg <= is_data_next;
            last_reg    <= last_next;
        end
    end

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_COLOUR)
        else $error("header step beyond colour phase");
    a_colour_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && step_reg == STEP_COLOUR |-> pixels_reg != 16'd0)
        else $error("colour phase running with no pixels left");
    a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
        pop && has_result && last_next |=> !busy_reg)
        else $error("final byte sent but job still busy");
    a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !busy_reg |-> !has_result)
        else $error("result produced while idle");

endmodule

FILE: rtl/tft_rectangle_fill_stream.sv
// Path: the result of a tick item passes through the queue and the back part's
// output register before it is offered.
// Throughput: one item per cycle in; at most one result per cycle out while the
// result side is ready. Items wait only when it stalls long enough to fill the queue.
// Reset (rst_n low, asynchronous): the job goes idle, the queue and output
// register empty, panel size returns to 128 x 160.
`timescale 1ns / 1ps

module tft_rectangle_fill_stream
#(
    parameter int unsigned QUEUE_DEPTH = tfill_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    tfill_req_if.sink   req,
    tfill_rsp_if.source rsp,
    tfill_cfg_if.sink   cfg
);

    // Front to back link: the front classifies each item (start or tick),
    // works out the window ends, the pixel count and the panel bounds check,
    // and pushes one entry per accepted item.
    tfill_pkg::tfill_entry_t        push_entry;
    tfill_pkg::tfill_entry_t        pop_entry;
    tfill_pkg::tfill_queue_status_t q_status;
    logic                           push;
    logic                           pop;

    // Accept items and hold the panel size registers.
    tfill_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg        (cfg),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decouple the two sides so that a stalled output does not stop intake
    // until the queue fills.
    tfill_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .status     (q_status)
    );

    // Advance the header walk and colour pixels; one entry per cycle whenever
    // the output register is free or being drained.
    tfill_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_entry (pop_entry),
        .q_status  (q_status),
        .pop       (pop),
        .rsp       (rsp)
    );

endmodule
